### sv/swml_pkg.sv
package swml_pkg;

    localparam int LEN_W         = 6;
    localparam int COL_W         = 16;
    localparam int LINE_W        = 24;
    localparam int CNT_W         = 24;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int BYTES_PER_REG = 8;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    typedef logic [7:0] t_byte;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LENGTH  = 3'd0,
        CFG_PATTERN_BYTES_0 = 3'd1,
        CFG_PATTERN_BYTES_1 = 3'd2,
        CFG_PATTERN_BYTES_2 = 3'd3,
        CFG_PATTERN_BYTES_3 = 3'd4
    } t_cfg_index;

    typedef enum logic {
        RESULT_MATCH = 1'b0,
        RESULT_TOTAL = 1'b1
    } t_result_kind;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

endpackage

### sv/swml_cfg.sv
module swml_cfg #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [swml_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [swml_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [MAX_PATTERN-1:0][7:0]          o_apat,
    output logic [MAX_PATTERN-1:0]               o_mask,
    output logic [swml_pkg::LEN_W-1:0]           o_back,
    output logic                                 o_len_nz
);
    import swml_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW1   = LEN_W + 1;

    t_byte                       r_pat [MAX_PATTERN];
    t_byte                       n_pat [MAX_PATTERN];
    logic [LEN_W-1:0]            r_len;
    logic [LEN_W-1:0]            n_len;
    logic [LEN_W-1:0]            len_c;
    logic [CFG_INDEX_W-1:0]      reg_sel;
    logic [MAX_PATTERN-1:0][7:0] r_apat;
    logic [MAX_PATTERN-1:0][7:0] n_apat;
    logic [MAX_PATTERN-1:0]      r_mask;
    logic [MAX_PATTERN-1:0]      n_mask;
    logic [LEN_W-1:0]            r_back;
    logic                        r_len_nz;

    // register write decode
    always_comb begin
        n_len   = r_len;
        reg_sel = i_cfg_index - CFG_PATTERN_BYTES_0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            n_pat[j] = r_pat[j];
        end
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index) inside
                CFG_PATTERN_LENGTH: begin
                    n_len = i_cfg_data[LEN_W-1:0];
                end
                CFG_PATTERN_BYTES_0, CFG_PATTERN_BYTES_1,
                CFG_PATTERN_BYTES_2, CFG_PATTERN_BYTES_3: begin
                    for (int j = 0; j < MAX_PATTERN; j++) begin
                        if (int'(reg_sel) == j / BYTES_PER_REG) begin
                            n_pat[j] = i_cfg_data[(j % BYTES_PER_REG)*8 +: 8];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // align the pattern so that window entry j faces pattern byte len-1-j
    always_comb begin
        logic [LW1-1:0] idx;
        idx = '0;
        if ({1'b0, n_len} > LW1'(MAX_PATTERN)) begin
            len_c = LEN_W'(MAX_PATTERN);
        end else begin
            len_c = n_len;
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (LW1'(j) < {1'b0, len_c}) begin
                idx       = {1'b0, len_c} - LW1'(1) - LW1'(j);
                n_apat[j] = n_pat[idx[IDX_W-1:0]];
                n_mask[j] = 1'b1;
            end else begin
                n_apat[j] = '0;
                n_mask[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_W'(1);
            r_apat   <= '0;
            r_mask   <= MAX_PATTERN'(1);
            r_back   <= '0;
            r_len_nz <= 1'b1;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_pat[j] <= '0;
            end
        end else begin
            r_len    <= n_len;
            r_apat   <= n_apat;
            r_mask   <= n_mask;
            r_back   <= len_c - LEN_W'(1);
            r_len_nz <= (len_c != '0);
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_pat[j] <= n_pat[j];
            end
        end
    end

    assign o_apat   = r_apat;
    assign o_mask   = r_mask;
    assign o_back   = r_back;
    assign o_len_nz = r_len_nz;

endmodule

### sv/swml_window.sv
module swml_window #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  swml_pkg::t_win_ctl          i_ctl,
    input  swml_pkg::t_byte             i_byte,
    input  logic [MAX_PATTERN-1:0][7:0] i_apat,
    input  logic [MAX_PATTERN-1:0]      i_mask,
    input  logic                        i_len_nz,
    output logic                        o_hit
);
    import swml_pkg::*;

    t_byte                  r_win [MAX_PATTERN];
    t_byte                  n_win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_vld;
    logic [MAX_PATTERN-1:0] n_vld;
    logic [MAX_PATTERN-1:0] pos_ok;

    // window after this byte goes in, entry 0 newest
    always_comb begin
        n_win[0] = i_byte;
        n_vld[0] = 1'b1;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
            n_vld[j] = r_vld[j-1];
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pos_ok[j] = !i_mask[j] || (n_vld[j] && (n_win[j] == i_apat[j]));
        end
    end

    assign o_hit = i_len_nz && (&pos_ok);

    // valid bits stand for the byte count of the line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clear) begin
            r_vld <= '0;
        end else if (i_ctl.shift) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= n_win[j];
            end
        end
    end

endmodule

### sv/stream_word_match_locator_core.sv
// stream word match locator
// input channel: one text byte per transaction (i_data_byte), or an end of
// file marker (i_file_end high, byte ignored). byte 10 ends a line.
// output channel: one result per match (kind 0, line, start column and
// running count) and one per end of file (kind 0 replaced by 1, total count,
// line and column zero). newlines and non-matching bytes give no result.
// configuration: write enable, index and 64-bit data; index 0 sets the
// pattern length, 1 to 4 set pattern bytes eight at a time, low byte first.
// write only while no transaction is in flight.
// a result is in the output register in the cycle after its input
// transaction is accepted. throughput: one byte per cycle while o_stall
// is low, set by the parallel compare of the whole window against the
// aligned pattern. when the receiver stalls, the held result stays and
// one more input transaction is taken only if the output register is free.
// reset clears counters, window and output valid; the pattern returns to
// length 1 with all bytes zero.
module stream_word_match_locator_core #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_file_end,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_result_kind,
    output logic [swml_pkg::LINE_W-1:0]       o_line_number,
    output logic [swml_pkg::COL_W-1:0]        o_start_column,
    output logic [swml_pkg::CNT_W-1:0]        o_occurrence_count,
    input  logic                              i_cfg_wr_en,
    input  logic [swml_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [swml_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import swml_pkg::*;

    logic [MAX_PATTERN-1:0][7:0] apat;
    logic [MAX_PATTERN-1:0]      mask;
    logic [LEN_W-1:0]            back;
    logic                        len_nz;
    t_win_ctl                    win_ctl;
    logic                        hit;
    logic                        in_acc;
    logic                        is_nl;
    logic                        is_data;

    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [LINE_W-1:0] r_line;
    logic [LINE_W-1:0] n_line;
    logic [CNT_W-1:0]  r_match;
    logic [CNT_W-1:0]  n_match;
    logic [CNT_W-1:0]  match_inc;
    logic [COL_W-1:0]  back_ext;

    logic              r_out_valid;
    logic              n_out_valid;
    t_result_kind      r_kind;
    t_result_kind      n_kind;
    logic [LINE_W-1:0] r_out_line;
    logic [LINE_W-1:0] n_out_line;
    logic [COL_W-1:0]  r_out_col;
    logic [COL_W-1:0]  n_out_col;
    logic [CNT_W-1:0]  r_out_cnt;
    logic [CNT_W-1:0]  n_out_cnt;

    swml_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_apat      (apat),
        .o_mask      (mask),
        .o_back      (back),
        .o_len_nz    (len_nz)
    );

    swml_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (win_ctl),
        .i_byte   (i_data_byte),
        .i_apat   (apat),
        .i_mask   (mask),
        .i_len_nz (len_nz),
        .o_hit    (hit)
    );

    // output register doubles as the skid stage
    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;
    assign is_nl   = !i_file_end && (i_data_byte == NEWLINE_BYTE);
    assign is_data = !i_file_end && !is_nl;

    assign win_ctl.shift = in_acc && is_data;
    assign win_ctl.clear = in_acc && !is_data;

    assign match_inc = (r_match != '1) ? r_match + CNT_W'(1) : r_match;
    assign back_ext  = {{(COL_W-LEN_W){1'b0}}, back};

    always_comb begin
        n_col       = r_col;
        n_line      = r_line;
        n_match     = r_match;
        n_out_valid = r_out_valid && i_stall;
        n_kind      = r_kind;
        n_out_line  = r_out_line;
        n_out_col   = r_out_col;
        n_out_cnt   = r_out_cnt;
        if (in_acc) begin
            if (i_file_end) begin
                n_col       = '0;
                n_line      = '0;
                n_match     = '0;
                n_out_valid = 1'b1;
                n_kind      = RESULT_TOTAL;
                n_out_line  = '0;
                n_out_col   = '0;
                n_out_cnt   = r_match;
            end else if (is_nl) begin
                n_col  = '0;
                n_line = (r_line != '1) ? r_line + LINE_W'(1) : r_line;
            end else begin
                n_col = (r_col != '1) ? r_col + COL_W'(1) : r_col;
                if (hit) begin
                    n_match     = match_inc;
                    n_out_valid = 1'b1;
                    n_kind      = RESULT_MATCH;
                    n_out_line  = r_line;
                    n_out_col   = (r_col >= back_ext) ? r_col - back_ext : '0;
                    n_out_cnt   = match_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_line      <= '0;
            r_match     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_line      <= n_line;
            r_match     <= n_match;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_out_line <= n_out_line;
        r_out_col  <= n_out_col;
        r_out_cnt  <= n_out_cnt;
    end

    assign o_valid            = r_out_valid;
    assign o_result_kind      = r_kind;
    assign o_line_number      = r_out_line;
    assign o_start_column     = r_out_col;
    assign o_occurrence_count = r_out_cnt;

    // end of file restarts line and match numbering
    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_file_end |=> r_line == '0 && r_match == '0 && r_col == '0)
        else $error("counters not cleared after end of file");

    // a match result always carries a nonzero running count
    a_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == RESULT_MATCH |-> o_occurrence_count != '0)
        else $error("match reported with zero count");

    // a file total carries no position
    a_total_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == RESULT_TOTAL |-> o_line_number == '0 && o_start_column == '0)
        else $error("file total with nonzero position");

    // a newline never leaves a result behind
    a_newline_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_file_end && i_data_byte == NEWLINE_BYTE |=> !o_valid)
        else $error("result produced by newline");

    // counters hold unless an input is accepted (column only advances by one or clears)
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_col) && $stable(r_line) && $stable(r_match))
        else $error("counters moved without an input transaction");

endmodule
